/* rtl/core/irpfd_pkg.sv */
// Shared types, constants and nominal-timing tables for the IR pulse frame decoder.
// Used by every module in rtl/core; no dependencies of its own.
package irpfd_pkg;

  // Frame layout
  localparam int FRAME_ENTRIES = 36;
  localparam int DATA_SYMBOLS  = 4;
  localparam int HDR_PAIRS     = 13;
  localparam int HDR_ENTRIES   = 2 * HDR_PAIRS;
  localparam int DATA_END      = HDR_ENTRIES + 2 * DATA_SYMBOLS;
  localparam bit DATA_FITS     = (DATA_END <= FRAME_ENTRIES);
  localparam int LONG_PAIR     = 9;
  localparam int IDX_W         = 6;
  localparam int IDX_MAX       = 63;

  // Timing nominals in microseconds
  localparam int MARK_FIRST  = 400;
  localparam int MARK_NOM    = 180;
  localparam int SPACE_BASE  = 250;
  localparam int SPACE_STEP  = 180;
  localparam int SPACE_LONG  = 610;
  localparam int SYM_BITS    = 2;
  localparam int SYM_VALUES  = 4;
  localparam int NOM_W       = 10;

  localparam int DUR_W = 16;
  localparam int TOL_W = 7;
  localparam int CMD_W = 8;
  localparam logic [TOL_W-1:0] TOL_RESET = 7'd25;

  // Classification of one entry, as handed from front to back
  localparam logic [2:0] KIND_NONE       = 3'd0;
  localparam logic [2:0] KIND_HDR_MARK   = 3'd1;
  localparam logic [2:0] KIND_P9_MARK    = 3'd2;
  localparam logic [2:0] KIND_HDR_SPACE  = 3'd3;
  localparam logic [2:0] KIND_P9_SPACE   = 3'd4;
  localparam logic [2:0] KIND_DATA_MARK  = 3'd5;
  localparam logic [2:0] KIND_DATA_SPACE = 3'd6;
  localparam logic [2:0] KIND_BEYOND     = 3'd7;

  typedef struct packed {
    logic             is_mark;
    logic [DUR_W-1:0] duration_us;
    logic             frame_end;
  } entry_t;

  typedef struct packed {
    logic             valid_res;
    logic [CMD_W-1:0] command;
    logic             long_space;
  } result_t;

  typedef struct packed {
    logic [2:0]          kind;
    logic                is_mark;
    logic                match_a;   // against the entry's own nominal
    logic                match_b;   // against the short pair-9 space
    logic                sym_found;
    logic [SYM_BITS-1:0] sym;
    logic                last;
    logic                len_ok;
  } cls_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  function automatic logic [NOM_W-1:0] hdr_mark_nom(input logic [3:0] pair);
    hdr_mark_nom = (pair == 4'd0) ? NOM_W'(MARK_FIRST) : NOM_W'(MARK_NOM);
  endfunction

  function automatic logic [NOM_W-1:0] hdr_space_nom(input logic [3:0] pair);
    unique case (pair)
      4'd2, 4'd9, 4'd10, 4'd12: hdr_space_nom = 10'd610;
      4'd4:                     hdr_space_nom = 10'd790;
      4'd5, 4'd11:              hdr_space_nom = 10'd430;
      default:                  hdr_space_nom = 10'd250;
    endcase
  endfunction

endpackage

/* rtl/core/irpfd_front.sv */
// Front end: tracks the entry index and classifies each accepted entry with its
// tolerance and symbol compares. Depends on irpfd_pkg.
module irpfd_front import irpfd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  entry_t           entry,
  input  logic [TOL_W-1:0] tolerance,
  output logic             push,
  output cls_t             cls,
  output logic [IDX_W-1:0] index
);

  logic [IDX_W-1:0]  entry_index;
  logic              lo_zero;
  logic [TOL_W-1:0]  tol_lo;
  logic [TOL_W:0]    tol_hi;
  logic [22:0]       d100;
  logic [NOM_W-1:0]  nom_a;
  logic [3:0]        pair;
  logic [SYM_VALUES-1:0] hit;
  logic [2:0]        kind;
  logic [SYM_BITS-1:0] sym;

  // d >= floor(n*lo/100)  <=>  100*d + 99 >= n*lo ; d <= floor(n*hi/100) <=> 100*d <= n*hi
  function automatic logic within_tol(input logic [22:0] dd, input logic [NOM_W-1:0] nom,
                                      input logic lz, input logic [TOL_W-1:0] lof,
                                      input logic [TOL_W:0] hif);
    logic [16:0] lo_p;
    logic [17:0] hi_p;
    lo_p = {7'd0, nom} * {10'd0, lof};
    hi_p = {8'd0, nom} * {10'd0, hif};
    within_tol = (lz || ({1'b0, dd} + 24'd99 >= {7'd0, lo_p})) && (dd <= {5'd0, hi_p});
  endfunction

  assign lo_zero = (tolerance >= 7'd100);
  assign tol_lo  = lo_zero ? '0 : 7'(7'd100 - tolerance);
  assign tol_hi  = 8'd100 + {1'b0, tolerance};
  assign d100    = {7'd0, entry.duration_us} * 23'd100;
  assign pair    = entry_index[4:1];
  assign index   = entry_index;
  assign push    = accept;

  always_comb begin
    kind  = KIND_NONE;
    nom_a = NOM_W'(MARK_NOM);
    if (entry_index >= IDX_W'(FRAME_ENTRIES)) begin
      kind = KIND_BEYOND;
    end else if (entry_index < IDX_W'(HDR_ENTRIES)) begin
      if (!entry_index[0]) begin
        kind  = (pair == 4'(LONG_PAIR)) ? KIND_P9_MARK : KIND_HDR_MARK;
        nom_a = hdr_mark_nom(pair);
      end else begin
        kind  = (pair == 4'(LONG_PAIR)) ? KIND_P9_SPACE : KIND_HDR_SPACE;
        nom_a = hdr_space_nom(pair);
      end
    end else if ({1'b0, entry_index} < 7'(DATA_END)) begin
      kind = entry_index[0] ? KIND_DATA_SPACE : KIND_DATA_MARK;
    end
  end

  // Data space windows: center 250 + v*180, half width 90
  always_comb begin
    logic [16:0] c;
    logic [16:0] d_up;
    d_up = {1'b0, entry.duration_us} + 17'(SPACE_STEP / 2);
    for (int v = 0; v < SYM_VALUES; v++) begin
      c      = 17'(SPACE_BASE + v * SPACE_STEP);
      hit[v] = (d_up >= c) && ({1'b0, entry.duration_us} <= c + 17'(SPACE_STEP / 2));
    end
  end

  always_comb begin
    sym = '0;
    for (int v = SYM_VALUES - 1; v >= 0; v--) begin
      if (hit[v]) sym = SYM_BITS'(v);
    end
  end

  assign cls = '{
    kind:      kind,
    is_mark:   entry.is_mark,
    match_a:   within_tol(d100, nom_a, lo_zero, tol_lo, tol_hi),
    match_b:   within_tol(d100, NOM_W'(SPACE_BASE), lo_zero, tol_lo, tol_hi),
    sym_found: |hit,
    sym:       sym,
    last:      entry.frame_end,
    len_ok:    DATA_FITS && (entry_index == IDX_W'(FRAME_ENTRIES - 1))
  };

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_index <= '0;
    end else if (accept) begin
      if (entry.frame_end) begin
        entry_index <= '0;
      end else if (entry_index != IDX_W'(IDX_MAX)) begin
        entry_index <= entry_index + 1'b1;
      end
    end
  end

endmodule

/* rtl/core/irpfd_queue.sv */
// Two-entry queue of classified entries between front and back.
// Depends on irpfd_pkg.
module irpfd_queue import irpfd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  cls_t    push_data,
  input  logic    pop,
  output cls_t    head,
  output q_stat_t stat
);

  cls_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head = slots[rd_ptr];
  assign stat = '{empty: (count == 2'd0), full: (count == 2'd2)};

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/irpfd_back.sv */
// Back end: applies classified entries to the frame state and holds the result
// register toward the receiver. Depends on irpfd_pkg.
module irpfd_back import irpfd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cls_t    head,
  input  logic    head_valid,
  output logic    pop,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic             failed, failed_next;
  logic             mark_matched, mark_matched_next;
  logic             pair_nine_mark_ok, pair_nine_mark_ok_next;
  logic [CMD_W-1:0] command_acc, command_acc_next;
  logic             long_flag, long_flag_next;
  logic             ok;

  // A non-final entry never needs the output slot
  assign pop = head_valid && (!head.last || !result_valid || !result_stall);

  always_comb begin
    failed_next            = failed;
    mark_matched_next      = mark_matched;
    pair_nine_mark_ok_next = pair_nine_mark_ok;
    command_acc_next       = command_acc;
    long_flag_next         = long_flag;
    unique case (head.kind)
      KIND_HDR_MARK, KIND_DATA_MARK: begin
        mark_matched_next = head.is_mark && head.match_a;
      end
      KIND_P9_MARK: begin
        mark_matched_next      = head.is_mark && head.match_a;
        pair_nine_mark_ok_next = head.is_mark && head.match_a;
      end
      KIND_HDR_SPACE: begin
        if (!mark_matched || head.is_mark || !head.match_a) failed_next = 1'b1;
      end
      KIND_P9_SPACE: begin
        if (!pair_nine_mark_ok || head.is_mark) begin
          failed_next = 1'b1;
        end else if (head.match_a) begin
          long_flag_next = 1'b1;
        end else if (head.match_b) begin
          long_flag_next = 1'b0;
        end else begin
          failed_next = 1'b1;
        end
      end
      KIND_DATA_SPACE: begin
        if (mark_matched && !head.is_mark && head.sym_found) begin
          command_acc_next = {command_acc[CMD_W-SYM_BITS-1:0], head.sym};
        end else begin
          failed_next = 1'b1;
        end
      end
      KIND_BEYOND: begin
        failed_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign ok = !failed_next && head.len_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      failed            <= 1'b0;
      mark_matched      <= 1'b0;
      pair_nine_mark_ok <= 1'b0;
      command_acc       <= '0;
      long_flag         <= 1'b1;
    end else if (pop) begin
      if (head.last) begin
        // drop per-frame state for the next frame
        failed            <= 1'b0;
        mark_matched      <= 1'b0;
        pair_nine_mark_ok <= 1'b0;
        command_acc       <= '0;
        long_flag         <= 1'b1;
      end else begin
        failed            <= failed_next;
        mark_matched      <= mark_matched_next;
        pair_nine_mark_ok <= pair_nine_mark_ok_next;
        command_acc       <= command_acc_next;
        long_flag         <= long_flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pop && head.last) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.last) begin
      result.valid_res  <= ok;
      result.command    <= ok ? command_acc_next : '0;
      result.long_space <= ok && long_flag_next;
    end
  end

endmodule

/* rtl/core/ir_pulse_frame_decoder_unit.sv */
// Top level of the IR pulse frame decoder: tolerance register, front end,
// entry queue and back end. Depends on irpfd_pkg and the irpfd_* modules.
//
// Usage:
//   entry channel (entry_valid / entry_stall / entry): one mark or space
//   duration per transfer; frame_end flags the last entry of a frame.
//   result channel (result_valid / result_stall / result): one decode result
//   per frame, sent after the entry carrying frame_end.
//   cfg channel (cfg_valid / cfg_ready / cfg_data): writes tolerance_pct;
//   cfg_ready is always high. Write only while no frame is in flight.
// Throughput: one entry per cycle while no result stall holds the queue full, set by
//   the combinational classify compares in the front end and the one-entry-per-cycle back end.
// Result path: the frame_end transfer writes a queue slot, and result_valid rises
//   when the back end pops that entry and loads the result register.
// Reset (rst, synchronous): tolerance returns to 25, frame state and queue
//   clear, no result is pending.
// Receiver stall: the result register holds; entries keep flowing until a
//   second frame_end reaches the back end, then the two-entry queue fills
//   and entry_stall rises.
module ir_pulse_frame_decoder_unit import irpfd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             entry_valid,
  output logic             entry_stall,
  input  entry_t           entry,
  output logic             result_valid,
  input  logic             result_stall,
  output result_t          result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [TOL_W-1:0] cfg_data
);

  logic [TOL_W-1:0] tolerance;
  logic             accept;
  logic             push;
  logic             pop;
  cls_t             cls;
  cls_t             head;
  q_stat_t          q_stat;
  logic [IDX_W-1:0] index;

  assign cfg_ready   = 1'b1;
  assign entry_stall = q_stat.full;
  assign accept      = entry_valid && !entry_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tolerance <= cfg_data;
    end
  end

  irpfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .entry     (entry),
    .tolerance (tolerance),
    .push      (push),
    .cls       (cls),
    .index     (index)
  );

  irpfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (cls),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  irpfd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (!q_stat.empty),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

`ifndef NO_ASSERTIONS
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.valid_res |-> result.command == '0 && !result.long_space)
    else $error("failed frame result carries nonzero fields");

  a_index_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && entry.frame_end |=> index == '0)
    else $error("entry index not cleared after frame end");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(!q_stat.empty))
    else $error("result raised with empty queue");
`endif

endmodule

/* bench/ir_pulse_frame_decoder_unit_test.sv */
// Self-checking bench for ir_pulse_frame_decoder_unit: short directed frames, then
// well-formed and broken random frames over several tolerance settings.
// Depends on irpfd_pkg and the decoder RTL only.
module ir_pulse_frame_decoder_unit_test;
  import irpfd_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 120;
  localparam int DRILL_ROWS  = 17;
  localparam int unsigned HDR_SPACE [HDR_PAIRS] =
    '{250, 250, 610, 250, 790, 430, 250, 250, 250, 610, 610, 430, 610};
  localparam result_t NO_FRAME = '{1'b0, 8'd0, 1'b0};

  typedef struct packed {
    entry_t  item;
    logic    typed;
    result_t want;
  } drill_row_t;

  // Frames too short to decode; every frame_end row must report a failed frame.
  drill_row_t drill [DRILL_ROWS] = '{
    '{'{1'b1, 16'd400,   1'b1}, 1'b1, NO_FRAME},
    '{'{1'b0, 16'd0,     1'b1}, 1'b1, NO_FRAME},
    '{'{1'b1, 16'd65535, 1'b1}, 1'b1, NO_FRAME},
    '{'{1'b0, 16'd65535, 1'b1}, 1'b1, NO_FRAME},
    '{'{1'b1, 16'd0,     1'b0}, 1'b0, NO_FRAME},
    '{'{1'b0, 16'd65535, 1'b1}, 1'b1, NO_FRAME},
    '{'{1'b1, 16'd400,   1'b0}, 1'b0, NO_FRAME},
    '{'{1'b0, 16'd250,   1'b1}, 1'b1, NO_FRAME},
    '{'{1'b1, 16'd400,   1'b0}, 1'b0, NO_FRAME},
    '{'{1'b1, 16'd180,   1'b0}, 1'b0, NO_FRAME},
    '{'{1'b0, 16'd250,   1'b1}, 1'b1, NO_FRAME},
    '{'{1'b0, 16'd400,   1'b0}, 1'b0, NO_FRAME},
    '{'{1'b1, 16'd250,   1'b1}, 1'b1, NO_FRAME},
    '{'{1'b1, 16'd499,   1'b0}, 1'b0, NO_FRAME},
    '{'{1'b0, 16'd312,   1'b0}, 1'b0, NO_FRAME},
    '{'{1'b1, 16'd225,   1'b0}, 1'b0, NO_FRAME},
    '{'{1'b0, 16'd188,   1'b1}, 1'b1, NO_FRAME}
  };

  logic             clk;
  logic             rst = 1'b1;
  logic             entry_valid = 1'b0;
  logic             entry_stall;
  entry_t           entry = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  result_t          result;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [TOL_W-1:0] cfg_data = '0;

  // decoder shadow state
  logic [TOL_W-1:0] tol_pct = TOL_RESET;
  logic [IDX_W-1:0] at_idx;
  bit               frame_bad, mark_good, p9_mark_good, long_seen;
  logic [CMD_W-1:0] cmd_acc;

  result_t     pending_decodes[$];
  entry_t      frame_buf[$];
  bit          calm;
  int          faults;
  int unsigned phase_sent;
  int          hold_cnt;
  int          quiet;

  ir_pulse_frame_decoder_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .entry_valid  (entry_valid),
    .entry_stall  (entry_stall),
    .entry        (entry),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned win_bound(int unsigned nom, bit upper);
    if (upper) return nom * (100 + tol_pct) / 100;
    return (tol_pct >= 100) ? 0 : nom * (100 - tol_pct) / 100;
  endfunction

  function automatic bit in_window(int unsigned d, int unsigned nom);
    return d >= win_bound(nom, 1'b0) && d <= win_bound(nom, 1'b1);
  endfunction

  function automatic void clear_frame();
    at_idx = '0;
    frame_bad = 1'b0;
    mark_good = 1'b0;
    p9_mark_good = 1'b0;
    cmd_acc = '0;
    long_seen = 1'b1;
  endfunction

  function automatic void decode_entry(input entry_t e, output bit has_res,
                                       output result_t r);
    int unsigned idx, d, pair, c, k, sym;
    bit hit;
    idx = at_idx;
    d = e.duration_us;
    pair = idx >> 1;
    has_res = 1'b0;
    r = NO_FRAME;
    if (idx >= FRAME_ENTRIES) begin
      frame_bad = 1'b1;
    end else if (idx < HDR_ENTRIES) begin
      if (idx[0] == 1'b0) begin
        mark_good = e.is_mark && in_window(d, (pair == 0) ? MARK_FIRST : MARK_NOM);
        if (pair == LONG_PAIR) p9_mark_good = mark_good;
      end else if (pair == LONG_PAIR) begin
        // long space wins over short when both windows fit
        if (!p9_mark_good || e.is_mark) frame_bad = 1'b1;
        else if (in_window(d, SPACE_LONG)) long_seen = 1'b1;
        else if (in_window(d, SPACE_BASE)) long_seen = 1'b0;
        else frame_bad = 1'b1;
      end else if (!mark_good || e.is_mark || !in_window(d, HDR_SPACE[pair])) begin
        frame_bad = 1'b1;
      end
    end else if (idx < DATA_END) begin
      if (((idx - HDR_ENTRIES) & 1) == 0) begin
        mark_good = e.is_mark && in_window(d, MARK_NOM);
      end else begin
        hit = 1'b0;
        sym = 0;
        if (mark_good && !e.is_mark) begin
          for (k = 0; k < SYM_VALUES && !hit; k++) begin
            c = SPACE_BASE + k * SPACE_STEP;
            if (d + SPACE_STEP / 2 >= c && d <= c + SPACE_STEP / 2) begin
              hit = 1'b1;
              sym = k;
            end
          end
        end
        if (hit) cmd_acc = CMD_W'((cmd_acc << SYM_BITS) + sym);
        else frame_bad = 1'b1;
      end
    end
    if (e.frame_end) begin
      has_res = 1'b1;
      if (!frame_bad && idx == FRAME_ENTRIES - 1 && DATA_FITS)
        r = '{1'b1, cmd_acc, long_seen};
      clear_frame();
    end else if (at_idx < IDX_MAX) begin
      at_idx = at_idx + 1'b1;
    end
  endfunction

  function automatic int unsigned pick_in(int unsigned nom);
    case ($urandom_range(0, 5))
      0:       return win_bound(nom, 1'b0);
      1:       return win_bound(nom, 1'b1);
      default: return $urandom_range(win_bound(nom, 1'b1), win_bound(nom, 1'b0));
    endcase
  endfunction

  // nominal of a checked entry, 0 for a data space
  function automatic int unsigned nominal_at(int unsigned i);
    if (i < HDR_ENTRIES) begin
      if (i[0] == 1'b0) return (i == 0) ? MARK_FIRST : MARK_NOM;
      return ((i >> 1) == LONG_PAIR) ? SPACE_LONG : HDR_SPACE[i >> 1];
    end
    return (i[0] == 1'b0) ? MARK_NOM : 0;
  endfunction

  function automatic void build_frame(bit long_sel, logic [7:0] syms, bit exact);
    int unsigned p, s, nom, c;
    frame_buf.delete();
    for (p = 0; p < HDR_PAIRS; p++) begin
      nom = (p == 0) ? MARK_FIRST : MARK_NOM;
      frame_buf.push_back('{1'b1, 16'(exact ? nom : pick_in(nom)), 1'b0});
      nom = (p == LONG_PAIR) ? (long_sel ? SPACE_LONG : SPACE_BASE) : HDR_SPACE[p];
      frame_buf.push_back('{1'b0, 16'(exact ? nom : pick_in(nom)), 1'b0});
    end
    for (s = 0; s < DATA_SYMBOLS; s++) begin
      frame_buf.push_back('{1'b1, 16'(exact ? MARK_NOM : pick_in(MARK_NOM)), 1'b0});
      c = SPACE_BASE + syms[7 - 2 * s -: 2] * SPACE_STEP;
      frame_buf.push_back('{1'b0,
        16'(exact ? c : c - SPACE_STEP / 2 + $urandom_range(SPACE_STEP, 0)), 1'b0});
    end
    while (frame_buf.size() < FRAME_ENTRIES)
      frame_buf.push_back('{1'(~frame_buf.size() & 1), 16'($urandom), 1'b0});
    frame_buf[frame_buf.size() - 1].frame_end = 1'b1;
  endfunction

  // span: target length for truncate, extra entries for extend; 0 draws one
  function automatic void break_frame(int mode, int span);
    int unsigned i, n, nom;
    i = $urandom_range(DATA_END - 1, 0);
    case (mode)
      0: begin
        n = (span != 0) ? span : $urandom_range(FRAME_ENTRIES - 1, 1);
        while (frame_buf.size() > n) void'(frame_buf.pop_back());
        frame_buf[frame_buf.size() - 1].frame_end = 1'b1;
      end
      1: begin
        n = (span != 0) ? span : $urandom_range(33, 1);
        frame_buf[frame_buf.size() - 1].frame_end = 1'b0;
        repeat (n) frame_buf.push_back('{1'($urandom), 16'($urandom), 1'b0});
        frame_buf[frame_buf.size() - 1].frame_end = 1'b1;
      end
      2: frame_buf[i].is_mark = ~frame_buf[i].is_mark;
      3: begin
        nom = nominal_at(i);
        if (nom == 0)
          frame_buf[i].duration_us = $urandom_range(0, 1) ? 16'($urandom_range(159, 0))
                                                          : 16'($urandom_range(2000, 881));
        else if (win_bound(nom, 1'b0) > 0 && $urandom_range(0, 1))
          frame_buf[i].duration_us = 16'(win_bound(nom, 1'b0) - 1);
        else
          frame_buf[i].duration_us = 16'(win_bound(nom, 1'b1) + 1);
      end
      4: frame_buf[i].duration_us = 16'($urandom);
      default: begin
        frame_buf.delete();
        repeat ($urandom_range(45, 1))
          frame_buf.push_back('{1'($urandom), 16'($urandom), $urandom_range(0, 7) == 0});
        frame_buf[frame_buf.size() - 1].frame_end = 1'b1;
      end
    endcase
  endfunction

  // Drop valid through a random gap unless calm is set; leave it high after the transfer.
  task automatic send_entry(input entry_t e, input bit typed, input result_t want);
    int gap;
    bit has_res;
    result_t r;
    gap = calm ? 0 : $urandom_range(12, 0);
    if (gap > 0) begin
      entry_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    entry_valid <= 1'b1;
    entry <= e;
    do @(posedge clk); while (entry_stall);
    decode_entry(e, has_res, r);
    if (has_res) pending_decodes.push_back(typed ? want : r);
    phase_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) send_entry(frame_buf[i], 1'b0, NO_FRAME);
  endtask

  task automatic drain_and_set_tol(input logic [TOL_W-1:0] value);
    entry_valid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tol_pct = value;
  endtask

  task automatic random_frames();
    phase_sent = 0;
    while (phase_sent < PHASE_ITEMS) begin
      calm = ($urandom_range(0, 5) == 0);
      build_frame(1'($urandom), 8'($urandom), $urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) >= 7) break_frame($urandom_range(5, 0), 0);
      send_frame();
    end
  endtask

  initial begin
    logic [TOL_W-1:0] tol_plan [6];
    tol_plan = '{7'd0, 7'd99, 7'd127, 7'd100, 7'($urandom_range(98, 1)),
                 7'($urandom_range(98, 1))};
    clear_frame();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (drill[i]) send_entry(drill[i].item, drill[i].typed, drill[i].want);
    // whole frames at reset tolerance: long and short, symbol extremes, boundaries
    build_frame(1'b1, 8'b00_01_10_11, 1'b1);
    send_frame();
    build_frame(1'b0, 8'hFF, 1'b1);
    send_frame();
    build_frame(1'b1, 8'h00, 1'b0);
    send_frame();
    // a space on the border of two symbols takes the lower one
    build_frame(1'b0, 8'h55, 1'b1);
    frame_buf[HDR_ENTRIES + 1].duration_us = 16'd340;
    frame_buf[HDR_ENTRIES + 3].duration_us = 16'd520;
    send_frame();
    build_frame(1'b1, 8'hA5, 1'b1);
    break_frame(1, 33);
    send_frame();
    build_frame(1'b1, 8'hA5, 1'b1);
    break_frame(0, FRAME_ENTRIES - 1);
    send_frame();
    build_frame(1'b0, 8'h3C, 1'b1);
    break_frame(2, 0);
    send_frame();
    random_frames();

    foreach (tol_plan[p]) begin
      drain_and_set_tol(tol_plan[p]);
      random_frames();
    end

    entry_valid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (faults == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // result side: check each transfer, then stall for a drawn number of cycles
  always @(posedge clk) begin : result_side
    int draw;
    result_t want;
    if (rst) begin
      result_stall <= 1'b0;
      hold_cnt <= 0;
    end else if (result_valid && !result_stall) begin
      if (pending_decodes.size() == 0) begin
        faults++;
        if (faults <= 10) $display("result with no decode pending: %p", result);
      end else begin
        want = pending_decodes.pop_front();
        if (result.valid_res !== want.valid_res || result.command !== want.command ||
            result.long_space !== want.long_space) begin
          faults++;
          if (faults <= 10)
            $display("decode mismatch: valid_res %0b/%0b command %02h/%02h long %0b/%0b",
                     want.valid_res, result.valid_res, want.command, result.command,
                     want.long_space, result.long_space);
        end
      end
      draw = calm ? 0 : $urandom_range(12, 0);
      result_stall <= (draw != 0);
      hold_cnt <= draw;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      if (hold_cnt == 1) result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (entry_valid && !entry_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("no transfer for %0d cycles, %0d decodes pending", quiet,
               pending_decodes.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule
